### hw/rtl/quad4_element_stiffness_defines.svh
// Assertion macros used by the checker file of the element stiffness block.
// No dependencies; include by bare file name.
`ifndef QUAD4_ELEMENT_STIFFNESS_DEFINES_SVH
`define QUAD4_ELEMENT_STIFFNESS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/qes_pkg.sv
// Shared types and constants of the element stiffness block.
// Used by the controller, the datapath and the top level.
package qes_pkg;

   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ENT_W      = 6;

   // per-entry sequencer lengths and the last entry index
   localparam int MUL_DRAIN  = 4;
   localparam int TMUL_DRAIN = 3;
   localparam int DIG_STEPS  = 13;
   localparam int ENT_LAST   = 63;

   localparam logic signed [31:0] D_XX_RST  = 32'sd72019;
   localparam logic signed [31:0] D_XY_RST  = 32'sd21606;
   localparam logic signed [31:0] D_XS_RST  = 32'sd0;
   localparam logic signed [31:0] D_YY_RST  = 32'sd72019;
   localparam logic signed [31:0] D_YS_RST  = 32'sd0;
   localparam logic signed [31:0] D_SS_RST  = 32'sd25206;
   localparam logic [31:0]        THICK_RST = 32'd65536;

   typedef enum logic [2:0] {
      CSR_D_XX      = 3'd0,
      CSR_D_XY      = 3'd1,
      CSR_D_XS      = 3'd2,
      CSR_D_YY      = 3'd3,
      CSR_D_YS      = 3'd4,
      CSR_D_SS      = 3'd5,
      CSR_THICKNESS = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_BA_LO = 3'd0,
      MUL_BA_HI = 3'd1,
      MUL_AB_LO = 3'd2,
      MUL_AB_HI = 3'd3,
      MUL_M0    = 3'd4,
      MUL_M1    = 3'd5,
      MUL_M2    = 3'd6
   } mul_sel_type;

   typedef struct packed {
      logic              load;
      logic              span;
      logic              sub;
      logic              div_start;
      logic              div_step;
      logic              div_save;
      logic              div_sel;
      logic              ent_init;
      logic              mul_issue;
      mul_sel_type       mul_sel;
      logic              take_abs;
      logic              round;
      logic              dig_step;
      logic              emit;
      logic [ENT_W-1:0]  ent_idx;
   } cmd_type;

   typedef struct packed {
      logic degen;
      logic out_full;
   } status_type;

endpackage

### hw/rtl/quad4_element_stiffness.sv
// Channel  | Dir | Word contents (lowest bits first)
// req      | in  | tdata: node0_x node0_y node1_x node1_y node2_x node2_y node3_x node3_y
// rsp      | out | tdata: row_index col_index entry_value; tuser: degenerate; tlast: last
// csr      | in  | write enable, index of register, 32-bit data
// One element runs two ratio divides of 33+FRAC_BITS steps each, then works through
// the entries in turn, each through the shared multiplier (seven products) and the
// 13-step divide-by-twelve digit unit.
// A zero-size element skips the divides and the arithmetic and emits zero entries.
// Synchronous reset, active high.
// A stalled rsp side holds the sequencer at the end of the current entry.
// Top level of the element stiffness block. Depends on qes_pkg, qes_ctrl, qes_datapath.
module quad4_element_stiffness #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // node0_x, node0_y, node1_x, node1_y, node2_x, node2_y, node3_x, node3_y
   input  logic [qes_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // row_index[2:0], col_index[5:3], entry_value[53:6], zero pad[55:54]
   output logic [qes_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // degenerate
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [qes_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qes_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   qes_pkg::cmd_type    cmd;
   qes_pkg::status_type status;

   qes_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qes_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/qes_ctrl.sv
// Sequencer of the element stiffness block: issues datapath commands per phase.
// Depends on qes_pkg.
module qes_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  qes_pkg::status_type  status,
   output qes_pkg::cmd_type     cmd
);

   localparam int DIV_STEPS = 33 + FRAC_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_SPAN, S_SUB, S_DSTART, S_DIV, S_DSAVE,
      S_EINIT, S_EMUL, S_EABS, S_ETMUL, S_ERND, S_EDIG, S_EEMIT
   } state_type;

   state_type                  state_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [qes_pkg::ENT_W-1:0]  ent_ff;
   logic                       dsel_ff;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = qes_pkg::MUL_BA_LO;
      cmd.ent_idx = ent_ff;
      cmd.div_sel = dsel_ff;
      case (state_ff)
         S_IDLE:   cmd.load      = req_tvalid;
         S_SPAN:   cmd.span      = 1'b1;
         S_SUB:    cmd.sub       = 1'b1;
         S_DSTART: cmd.div_start = !status.degen;
         S_DIV:    cmd.div_step  = 1'b1;
         S_DSAVE:  cmd.div_save  = 1'b1;
         S_EINIT:  cmd.ent_init  = 1'b1;
         S_EMUL: begin
            cmd.mul_issue = (step_ff != STEP_W'(qes_pkg::MUL_DRAIN));
            case (step_ff[1:0])
               2'd0:    cmd.mul_sel = qes_pkg::MUL_BA_LO;
               2'd1:    cmd.mul_sel = qes_pkg::MUL_BA_HI;
               2'd2:    cmd.mul_sel = qes_pkg::MUL_AB_LO;
               default: cmd.mul_sel = qes_pkg::MUL_AB_HI;
            endcase
         end
         S_EABS:   cmd.take_abs  = 1'b1;
         S_ETMUL: begin
            cmd.mul_issue = (step_ff != STEP_W'(qes_pkg::TMUL_DRAIN));
            case (step_ff[1:0])
               2'd0:    cmd.mul_sel = qes_pkg::MUL_M0;
               2'd1:    cmd.mul_sel = qes_pkg::MUL_M1;
               default: cmd.mul_sel = qes_pkg::MUL_M2;
            endcase
         end
         S_ERND:   cmd.round     = 1'b1;
         S_EDIG:   cmd.dig_step  = 1'b1;
         S_EEMIT:  cmd.emit      = !status.out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         ent_ff   <= '0;
         dsel_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               ent_ff  <= '0;
               dsel_ff <= 1'b0;
               if (req_tvalid) begin
                  state_ff <= S_SPAN;
               end
            end
            S_SPAN: state_ff <= S_SUB;
            S_SUB:  state_ff <= S_DSTART;
            S_DSTART: begin
               step_ff <= '0;
               // zero-size element: skip ratios and arithmetic, emit zeros
               if (status.degen) begin
                  state_ff <= S_EEMIT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_DSAVE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_DSAVE: begin
               if (!dsel_ff) begin
                  dsel_ff  <= 1'b1;
                  state_ff <= S_DSTART;
               end else begin
                  state_ff <= S_EINIT;
               end
            end
            S_EINIT: begin
               step_ff  <= '0;
               state_ff <= S_EMUL;
            end
            S_EMUL: begin
               if (step_ff == STEP_W'(qes_pkg::MUL_DRAIN)) begin
                  step_ff  <= '0;
                  state_ff <= S_EABS;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_EABS: state_ff <= S_ETMUL;
            S_ETMUL: begin
               if (step_ff == STEP_W'(qes_pkg::TMUL_DRAIN)) begin
                  step_ff  <= '0;
                  state_ff <= S_ERND;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_ERND: state_ff <= S_EDIG;
            S_EDIG: begin
               if (step_ff == STEP_W'(qes_pkg::DIG_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_EEMIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_EEMIT: begin
               // hold until the output word has been taken
               if (!status.out_full) begin
                  if (ent_ff == qes_pkg::ENT_W'(qes_pkg::ENT_LAST)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ent_ff <= ent_ff + 1'b1;
                     if (status.degen) begin
                        state_ff <= S_EEMIT;
                     end else begin
                        state_ff <= S_EINIT;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### hw/rtl/qes_datapath.sv
// Datapath of the element stiffness block: config registers, span, ratio divider,
// shared multiplier with accumulator, divide-by-twelve digit unit, output word.
// Depends on qes_pkg.
module qes_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qes_pkg::cmd_type                   cmd,
   output qes_pkg::status_type                status,
   input  logic [qes_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               csr_we,
   input  logic [qes_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qes_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [qes_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int R_W  = 33 + FRAC_BITS;   // ratio width
   localparam int RH_W = R_W - 32;
   localparam int S_W  = R_W + 37;         // magnitude of the inner sum
   localparam int MH_W = S_W - 64;
   localparam int A_W  = S_W + 32;         // accumulator
   localparam int X_W  = A_W - 2 * FRAC_BITS;
   localparam int Q_W  = 52;
   localparam logic [Q_W-1:0] POS_LIM = 52'h7FFF_FFFF_FFFF;
   localparam logic [Q_W-1:0] NEG_LIM = 52'h8000_0000_0000;

   // configuration
   logic signed [31:0] d_xx_ff, d_xy_ff, d_xs_ff, d_yy_ff, d_ys_ff, d_ss_ff;
   logic [31:0]        thick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_xx_ff  <= qes_pkg::D_XX_RST;
         d_xy_ff  <= qes_pkg::D_XY_RST;
         d_xs_ff  <= qes_pkg::D_XS_RST;
         d_yy_ff  <= qes_pkg::D_YY_RST;
         d_ys_ff  <= qes_pkg::D_YS_RST;
         d_ss_ff  <= qes_pkg::D_SS_RST;
         thick_ff <= qes_pkg::THICK_RST;
      end else if (csr_we) begin
         case (csr_index)
            qes_pkg::CSR_D_XX:      d_xx_ff  <= csr_wdata;
            qes_pkg::CSR_D_XY:      d_xy_ff  <= csr_wdata;
            qes_pkg::CSR_D_XS:      d_xs_ff  <= csr_wdata;
            qes_pkg::CSR_D_YY:      d_yy_ff  <= csr_wdata;
            qes_pkg::CSR_D_YS:      d_ys_ff  <= csr_wdata;
            qes_pkg::CSR_D_SS:      d_ss_ff  <= csr_wdata;
            qes_pkg::CSR_THICKNESS: thick_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // coordinates and span
   logic signed [31:0] crd_x_ff [4];
   logic signed [31:0] crd_y_ff [4];
   logic signed [31:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic signed [31:0] xmin_in, xmax_in, ymin_in, ymax_in;
   logic signed [31:0] xa_lo, xa_hi, xb_lo, xb_hi, ya_lo, ya_hi, yb_lo, yb_hi;
   logic signed [32:0] dx_in, dy_in;
   logic [31:0]        wid_ff, hgt_ff;
   logic               degen_ff;

   always_comb begin
      xa_lo   = (crd_x_ff[0] < crd_x_ff[1]) ? crd_x_ff[0] : crd_x_ff[1];
      xa_hi   = (crd_x_ff[0] < crd_x_ff[1]) ? crd_x_ff[1] : crd_x_ff[0];
      xb_lo   = (crd_x_ff[2] < crd_x_ff[3]) ? crd_x_ff[2] : crd_x_ff[3];
      xb_hi   = (crd_x_ff[2] < crd_x_ff[3]) ? crd_x_ff[3] : crd_x_ff[2];
      ya_lo   = (crd_y_ff[0] < crd_y_ff[1]) ? crd_y_ff[0] : crd_y_ff[1];
      ya_hi   = (crd_y_ff[0] < crd_y_ff[1]) ? crd_y_ff[1] : crd_y_ff[0];
      yb_lo   = (crd_y_ff[2] < crd_y_ff[3]) ? crd_y_ff[2] : crd_y_ff[3];
      yb_hi   = (crd_y_ff[2] < crd_y_ff[3]) ? crd_y_ff[3] : crd_y_ff[2];
      xmin_in = (xa_lo < xb_lo) ? xa_lo : xb_lo;
      xmax_in = (xa_hi > xb_hi) ? xa_hi : xb_hi;
      ymin_in = (ya_lo < yb_lo) ? ya_lo : yb_lo;
      ymax_in = (ya_hi > yb_hi) ? ya_hi : yb_hi;
      dx_in   = 33'(xmax_ff) - 33'(xmin_ff);
      dy_in   = 33'(ymax_ff) - 33'(ymin_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 4; k++) begin
            crd_x_ff[k] <= req_tdata[64 * k +: 32];
            crd_y_ff[k] <= req_tdata[64 * k + 32 +: 32];
         end
      end
      if (cmd.span) begin
         xmin_ff <= xmin_in;
         xmax_ff <= xmax_in;
         ymin_ff <= ymin_in;
         ymax_ff <= ymax_in;
      end
      if (cmd.sub) begin
         wid_ff <= dx_in[31:0];
         hgt_ff <= dy_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degen_ff <= 1'b0;
      end else if (cmd.sub) begin
         degen_ff <= (dx_in == '0) || (dy_in == '0);
      end
   end

   // restoring divider for the two ratios, quotient shifts into num_ff
   logic [R_W-1:0] num_ff, rba_ff, rab_ff;
   logic [31:0]    rem_ff, den_ff;
   logic [32:0]    dtry_in, ddif_in;
   logic           dge_in;

   always_comb begin
      dtry_in = {rem_ff, num_ff[R_W-1]};
      dge_in  = (dtry_in >= {1'b0, den_ff});
      ddif_in = dtry_in - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         if (!cmd.div_sel) begin
            num_ff <= (R_W'(hgt_ff) << FRAC_BITS) + R_W'(wid_ff[31:1]);
            den_ff <= wid_ff;
         end else begin
            num_ff <= (R_W'(wid_ff) << FRAC_BITS) + R_W'(hgt_ff[31:1]);
            den_ff <= hgt_ff;
         end
      end else if (cmd.div_step) begin
         rem_ff <= dge_in ? ddif_in[31:0] : dtry_in[31:0];
         num_ff <= {num_ff[R_W-2:0], dge_in};
      end
      if (cmd.div_save) begin
         if (!cmd.div_sel) begin
            rba_ff <= num_ff;
         end else begin
            rab_ff <= num_ff;
         end
      end
   end

   // entry coefficients from corner signs
   logic [2:0]         ent_p, ent_q;
   logic [1:0]         ent_i, ent_j;
   logic               xn_i, xn_j, en_i, en_j;
   logic signed [31:0] sel_a, sel_b, sel_c, sel_e;
   logic signed [34:0] dap_in, dbp_in, dap_ff, dbp_ff;
   logic signed [35:0] tc_in, te_in, rsum_in, r3_in;

   always_comb begin
      ent_p = cmd.ent_idx[5:3];
      ent_q = cmd.ent_idx[2:0];
      ent_i = ent_p[2:1];
      ent_j = ent_q[2:1];
      xn_i  = ~(ent_i[1] ^ ent_i[0]);
      xn_j  = ~(ent_j[1] ^ ent_j[0]);
      en_i  = ~ent_i[1];
      en_j  = ~ent_j[1];
      case ({ent_p[0], ent_q[0]})
         2'b00: begin
            sel_a = d_xx_ff; sel_b = d_ss_ff; sel_c = d_xs_ff; sel_e = d_xs_ff;
         end
         2'b01: begin
            sel_a = d_xs_ff; sel_b = d_ys_ff; sel_c = d_xy_ff; sel_e = d_ss_ff;
         end
         2'b10: begin
            sel_a = d_xs_ff; sel_b = d_ys_ff; sel_c = d_ss_ff; sel_e = d_xy_ff;
         end
         default: begin
            sel_a = d_ss_ff; sel_b = d_yy_ff; sel_c = d_ys_ff; sel_e = d_ys_ff;
         end
      endcase
      // factor 4 when the other-axis signs agree, else 2
      dap_in  = (en_i == en_j) ? (35'(sel_a) <<< 2) : (35'(sel_a) <<< 1);
      dbp_in  = (xn_i == xn_j) ? (35'(sel_b) <<< 2) : (35'(sel_b) <<< 1);
      if (xn_i ^ xn_j) begin
         dap_in = -dap_in;
      end
      if (en_i ^ en_j) begin
         dbp_in = -dbp_in;
      end
      tc_in   = (xn_i ^ en_j) ? -36'(sel_c) : 36'(sel_c);
      te_in   = (en_i ^ xn_j) ? -36'(sel_e) : 36'(sel_e);
      rsum_in = tc_in + te_in;
      r3_in   = rsum_in + (rsum_in <<< 1);
   end

   // shared multiplier, product registered before accumulation
   logic signed [32:0]    op_a;
   logic signed [35:0]    op_b;
   logic [6:0]            op_sh;
   logic signed [68:0]    prod_ff;
   logic [6:0]            prod_sh_ff;
   logic                  prod_vld_ff;
   logic signed [A_W-1:0] acc_ff;
   logic [S_W-1:0]        mag_ff;
   logic                  neg_ff;
   logic [A_W-1:0]        abs_in, rnd_in;
   logic [X_W-1:0]        xs_in;

   always_comb begin
      op_a  = '0;
      op_b  = 36'(dap_ff);
      op_sh = 7'd0;
      case (cmd.mul_sel)
         qes_pkg::MUL_BA_LO: begin
            op_a = $signed({1'b0, rba_ff[31:0]});
            op_b = 36'(dap_ff);
         end
         qes_pkg::MUL_BA_HI: begin
            op_a  = $signed({{(33 - RH_W){1'b0}}, rba_ff[R_W-1:32]});
            op_b  = 36'(dap_ff);
            op_sh = 7'd32;
         end
         qes_pkg::MUL_AB_LO: begin
            op_a = $signed({1'b0, rab_ff[31:0]});
            op_b = 36'(dbp_ff);
         end
         qes_pkg::MUL_AB_HI: begin
            op_a  = $signed({{(33 - RH_W){1'b0}}, rab_ff[R_W-1:32]});
            op_b  = 36'(dbp_ff);
            op_sh = 7'd32;
         end
         qes_pkg::MUL_M0: begin
            op_a = $signed({1'b0, mag_ff[31:0]});
            op_b = $signed({4'b0000, thick_ff});
         end
         qes_pkg::MUL_M1: begin
            op_a  = $signed({1'b0, mag_ff[63:32]});
            op_b  = $signed({4'b0000, thick_ff});
            op_sh = 7'd32;
         end
         qes_pkg::MUL_M2: begin
            op_a  = $signed({{(33 - MH_W){1'b0}}, mag_ff[S_W-1:64]});
            op_b  = $signed({4'b0000, thick_ff});
            op_sh = 7'd64;
         end
         default: ;
      endcase
      abs_in = acc_ff[A_W-1] ? A_W'(-acc_ff) : A_W'(acc_ff);
      rnd_in = $unsigned(acc_ff) + (A_W'(6) << (2 * FRAC_BITS));
      xs_in  = rnd_in[A_W-1:2*FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_issue) begin
         prod_ff    <= op_a * op_b;
         prod_sh_ff <= op_sh;
      end
      if (cmd.ent_init) begin
         dap_ff <= dap_in;
         dbp_ff <= dbp_in;
         acc_ff <= A_W'(r3_in) <<< FRAC_BITS;
      end else if (cmd.take_abs) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + (A_W'(prod_ff) <<< prod_sh_ff);
      end
      if (cmd.take_abs) begin
         neg_ff <= acc_ff[A_W-1];
         mag_ff <= abs_in[S_W-1:0];
      end
   end

   // divide by twelve, one hex digit per step
   logic [Q_W-1:0] dvd_ff, q_ff;
   logic [3:0]     r12_ff;
   logic           sat_ff;
   logic [7:0]     dv_in, drem_in;
   logic [3:0]     digit_in;

   always_comb begin
      dv_in    = {r12_ff, dvd_ff[Q_W-1:Q_W-4]};
      digit_in = 4'd0;
      for (int k = 1; k < 16; k++) begin
         if (dv_in >= 8'(12 * k)) begin
            digit_in = 4'(k);
         end
      end
      drem_in = dv_in - 8'({digit_in, 3'b000}) - 8'({digit_in, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         sat_ff <= |xs_in[X_W-1:Q_W];
         dvd_ff <= xs_in[Q_W-1:0];
         q_ff   <= '0;
         r12_ff <= '0;
      end else if (cmd.dig_step) begin
         dvd_ff <= {dvd_ff[Q_W-5:0], 4'b0000};
         q_ff   <= {q_ff[Q_W-5:0], digit_in};
         r12_ff <= drem_in[3:0];
      end
   end

   // saturate and sign the entry
   logic [Q_W-1:0] lim_in, qsat_in;
   logic [47:0]    val_in;

   always_comb begin
      lim_in  = neg_ff ? NEG_LIM : POS_LIM;
      qsat_in = (sat_ff || (q_ff > lim_in)) ? lim_in : q_ff;
      val_in  = neg_ff ? (48'd0 - qsat_in[47:0]) : qsat_in[47:0];
      if (degen_ff) begin
         val_in = '0;
      end
   end

   logic                              rsp_tvalid_ff;
   logic [qes_pkg::RSP_DATA_W-1:0]    rsp_tdata_ff;
   logic                              rsp_tuser_ff, rsp_tlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata_ff <= {2'b00, val_in, cmd.ent_idx[2:0], cmd.ent_idx[5:3]};
         rsp_tuser_ff <= degen_ff;
         rsp_tlast_ff <= (cmd.ent_idx == qes_pkg::ENT_W'(qes_pkg::ENT_LAST));
      end
   end

   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_tdata       = rsp_tdata_ff;
   assign rsp_tuser       = rsp_tuser_ff;
   assign rsp_tlast       = rsp_tlast_ff;
   assign status.degen    = degen_ff;
   assign status.out_full = rsp_tvalid_ff;

endmodule

### hw/rtl/qes_checker.sv
// Port-level checks of the element stiffness block, bound to the top level.
// Depends on quad4_element_stiffness_defines.svh.
`include "quad4_element_stiffness_defines.svh"

module qes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // one element at a time: busy right after a word is taken
   `QES_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "req ready after accept")
   // last word of a matrix sits at row 7, column 7
   `QES_ASSERT_SAME(a_last_corner, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[5:0] == 6'h3f, "last word not at row 7 col 7")
   // zero-size element yields zero entries
   `QES_ASSERT_SAME(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[53:6] == 48'd0, "degenerate word with nonzero entry")
   // stalled result word holds
   `QES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed under stall")

endmodule

bind quad4_element_stiffness qes_checker u_qes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### tb/tb_quad4_element_stiffness.sv
// Self-checking testbench of the element stiffness block: drives element words,
// predicts all 64 matrix entries of each and compares every response word.
// Depends on qes_pkg and quad4_element_stiffness.
module tb_quad4_element_stiffness;

   localparam int FRAC         = 16;
   localparam int IDLE_LIMIT   = 20000;
   localparam int MAX_REPORTS  = 10;
   localparam logic [2:0] CSR_NONE = 3'd7;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [47:0] value;
      logic        degen;
      logic        last;
   } entry_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [qes_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [qes_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we;
   logic [qes_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [qes_pkg::CSR_DATA_W-1:0] csr_wdata;

   quad4_element_stiffness #(.FRAC_BITS(FRAC)) dut (.*);

   // material and thickness shadow
   logic signed [31:0] m_xx, m_xy, m_xs, m_yy, m_ys, m_ss;
   logic [31:0]        m_thick;

   logic [qes_pkg::REQ_DATA_W-1:0] element_q[$];
   entry_type             entry_q[$];
   int                    errors;
   int                    accepted_cnt;
   int                    driven_cnt;
   int                    burst_left;
   int                    gap_left;
   int                    ready_pct;
   int                    stall_phase;
   int                    idle_cycles;

   const int corner_xi[4]  = '{-1, 1, 1, -1};
   const int corner_eta[4] = '{-1, -1, 1, 1};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [47:0] stiff_entry(logic [63:0] rba, logic [63:0] rab,
                                               longint p, longint q, longint r);
      logic signed [127:0] s;
      logic signed [127:0] pw, qw, rw, aw, bw;
      logic [127:0]        mag, prod, quo, lim;
      logic                neg;
      aw = rba;
      bw = rab;
      pw = p;
      qw = q;
      rw = r;
      s = aw * pw + bw * qw + (rw <<< FRAC);
      neg = s[127];
      mag = neg ? -s : s;
      prod = mag * {96'b0, m_thick} + (128'd6 << (2 * FRAC));
      quo = (prod >> (2 * FRAC)) / 12;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (quo > lim) quo = lim;
      return neg ? 48'(-quo) : quo[47:0];
   endfunction

   function automatic void predict_stiffness(logic [qes_pkg::REQ_DATA_W-1:0] w);
      logic signed [31:0] x, y, xmin, xmax, ymin, ymax;
      logic [63:0]        wd, ht, rba, rab;
      logic               degen;
      entry_type          e;
      int                 p, q, i, j, cxx, cyy, cc, ce;
      longint             da, db, dc, de;
      xmin = w[31:0];
      xmax = xmin;
      ymin = w[63:32];
      ymax = ymin;
      for (int k = 1; k < 4; k++) begin
         x = w[64*k +: 32];
         y = w[64*k+32 +: 32];
         if (x < xmin) xmin = x;
         if (x > xmax) xmax = x;
         if (y < ymin) ymin = y;
         if (y > ymax) ymax = y;
      end
      wd = 64'(longint'(xmax) - longint'(xmin));
      ht = 64'(longint'(ymax) - longint'(ymin));
      degen = (wd == 0) || (ht == 0);
      rba = 0;
      rab = 0;
      if (!degen) begin
         rba = ((ht << FRAC) + wd / 2) / wd;
         rab = ((wd << FRAC) + ht / 2) / ht;
      end
      for (int k = 0; k < 64; k++) begin
         p = k >> 3;
         q = k & 7;
         i = p >> 1;
         j = q >> 1;
         if (!p[0] && !q[0]) begin
            da = m_xx; db = m_ss; dc = m_xs; de = m_xs;
         end else if (!p[0]) begin
            da = m_xs; db = m_ys; dc = m_xy; de = m_ss;
         end else if (!q[0]) begin
            da = m_xs; db = m_ys; dc = m_ss; de = m_xy;
         end else begin
            da = m_ss; db = m_yy; dc = m_ys; de = m_ys;
         end
         cxx = corner_xi[i] * corner_xi[j] * (3 + corner_eta[i] * corner_eta[j]);
         cyy = corner_eta[i] * corner_eta[j] * (3 + corner_xi[i] * corner_xi[j]);
         cc = 3 * corner_xi[i] * corner_eta[j];
         ce = 3 * corner_eta[i] * corner_xi[j];
         e.row = p[2:0];
         e.col = q[2:0];
         e.degen = degen;
         e.last = (k == 63);
         e.value = degen ? 48'd0 : stiff_entry(rba, rab, cxx * da, cyy * db, cc * dc + ce * de);
         entry_q.push_back(e);
      end
   endfunction

   // sender: hold the word until taken, bursts separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         driven_cnt <= 0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(req_tvalid && accepted_cnt != driven_cnt)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (element_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= element_q[0];
            driven_cnt <= driven_cnt + 1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 5);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: ready probability picked anew at random from 100, 75, 30 or 5 percent
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_phase <= 0;
         ready_pct <= 100;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase % 64 == 63) begin
            case ($urandom_range(0, 3))
               0: ready_pct <= 100;
               1: ready_pct <= 75;
               2: ready_pct <= 30;
               default: ready_pct <= 5;
            endcase
         end
         rsp_tready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   always @(posedge clock) begin
      entry_type e;
      if (reset) begin
         accepted_cnt <= 0;
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_stiffness(req_tdata);
            void'(element_q.pop_front());
            accepted_cnt <= accepted_cnt + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (entry_q.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected response word %h", rsp_tdata);
            end else begin
               e = entry_q.pop_front();
               if (rsp_tdata[2:0] !== e.row || rsp_tdata[5:3] !== e.col ||
                   rsp_tdata[53:6] !== e.value || rsp_tuser !== e.degen ||
                   rsp_tlast !== e.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("mismatch: expected row %0d col %0d value %h degen %b last %b, got row %0d col %0d value %h degen %b last %b",
                              e.row, e.col, e.value, e.degen, e.last, rsp_tdata[2:0],
                              rsp_tdata[5:3], rsp_tdata[53:6], rsp_tuser, rsp_tlast);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         qes_pkg::CSR_D_XX:      m_xx = v;
         qes_pkg::CSR_D_XY:      m_xy = v;
         qes_pkg::CSR_D_XS:      m_xs = v;
         qes_pkg::CSR_D_YY:      m_yy = v;
         qes_pkg::CSR_D_YS:      m_ys = v;
         qes_pkg::CSR_D_SS:      m_ss = v;
         qes_pkg::CSR_THICKNESS: m_thick = v;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_material(logic [31:0] xx, logic [31:0] xy, logic [31:0] xs,
                               logic [31:0] yy, logic [31:0] ys, logic [31:0] ss,
                               logic [31:0] th);
      csr_write(qes_pkg::CSR_D_XX, xx);
      csr_write(qes_pkg::CSR_D_XY, xy);
      csr_write(qes_pkg::CSR_D_XS, xs);
      csr_write(qes_pkg::CSR_D_YY, yy);
      csr_write(qes_pkg::CSR_D_YS, ys);
      csr_write(qes_pkg::CSR_D_SS, ss);
      csr_write(qes_pkg::CSR_THICKNESS, th);
   endtask

   function automatic logic [qes_pkg::REQ_DATA_W-1:0] corners(
                                                     logic [31:0] x0, logic [31:0] y0,
                                                     logic [31:0] x1, logic [31:0] y1,
                                                     logic [31:0] x2, logic [31:0] y2,
                                                     logic [31:0] x3, logic [31:0] y3);
      return {y3, x3, y2, x2, y1, x1, y0, x0};
   endfunction

   function automatic logic [31:0] random_span();
      case ($urandom_range(0, 9))
         0:       return 0;
         1, 2:    return $urandom;
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 16);
         default: return $urandom_range(1, 32'h0008_0000);
      endcase
   endfunction

   // mostly rectangles with random origin, size and corner order; some noise
   function automatic logic [qes_pkg::REQ_DATA_W-1:0] random_element();
      logic [31:0] x0, y0, x1, y1;
      logic [31:0] cx[4], cy[4];
      int          rot;
      if ($urandom_range(0, 4) == 0)
         return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      x0 = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      y0 = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      x1 = x0 + random_span();
      y1 = y0 + random_span();
      cx = '{x0, x1, x1, x0};
      cy = '{y0, y0, y1, y1};
      rot = $urandom_range(0, 3);
      if ($urandom_range(0, 1) == 0)
         return corners(cx[rot], cy[rot], cx[(rot+1)%4], cy[(rot+1)%4],
                        cx[(rot+2)%4], cy[(rot+2)%4], cx[(rot+3)%4], cy[(rot+3)%4]);
      return corners(cx[rot], cy[rot], cx[(rot+3)%4], cy[(rot+3)%4],
                     cx[(rot+2)%4], cy[(rot+2)%4], cx[(rot+1)%4], cy[(rot+1)%4]);
   endfunction

   task automatic wait_drained();
      while (element_q.size() != 0 || entry_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) element_q.push_back(random_element());
      wait_drained();
   endtask

   initial begin
      errors = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = qes_pkg::CSR_D_XX;
      csr_wdata = '0;
      m_xx = qes_pkg::D_XX_RST;
      m_xy = qes_pkg::D_XY_RST;
      m_xs = qes_pkg::D_XS_RST;
      m_yy = qes_pkg::D_YY_RST;
      m_ys = qes_pkg::D_YS_RST;
      m_ss = qes_pkg::D_SS_RST;
      m_thick = qes_pkg::THICK_RST;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero size, unit square, flat strips, extreme spans, odd shapes
      element_q.push_back('0);
      element_q.push_back(corners(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0, 32'h10000));
      element_q.push_back(corners(5, 0, 5, 32'h20000, 5, 7, 5, 9));
      element_q.push_back(corners(0, 3, 32'h30000, 3, 17, 3, 9, 3));
      element_q.push_back(corners(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      element_q.push_back(corners(0, 32'h8000_0000, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF,
                                  0, 32'h7FFF_FFFF));
      element_q.push_back(corners(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1,
                                  32'h8000_0000, 1));
      element_q.push_back(corners(32'hFFFE_0000, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFF_8000,
                                  32'hFFFF_0000, 32'hFFFF_8000, 32'hFFFF_0000, 32'hFFFF_0000));
      element_q.push_back(corners(32'h20000, 32'h10000, 0, 0, 32'h20000, 0, 0, 32'h10000));
      element_q.push_back(corners(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                                  32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678, 32'h8765_4321));
      element_q.push_back(corners(0, 0, 3, 0, 3, 32'h10001, 0, 32'h10001));
      wait_drained();
      run_random(15);

      // largest positive material and thickness drive saturation
      set_material(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      element_q.push_back(corners(0, 0, 1, 0, 1, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF));
      run_random(15);

      set_material(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      run_random(15);

      set_material($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
      csr_write(CSR_NONE, $urandom);
      run_random(10);

      set_material($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0002_0000),
                   $urandom_range(0, 32'h0000_8000), $urandom_range(0, 32'h0004_0000),
                   $urandom_range(0, 32'h0000_8000), $urandom_range(0, 32'h0002_0000),
                   $urandom_range(1, 32'h0004_0000));
      run_random(20);

      set_material($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(20);

      repeat (200) @(negedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/qes_pkg.sv
hw/rtl/qes_ctrl.sv
hw/rtl/qes_datapath.sv
hw/rtl/quad4_element_stiffness.sv
hw/rtl/qes_checker.sv
tb/tb_quad4_element_stiffness.sv
